>>> sv/assert_macros.svh
// Assertion shorthands shared by the converter RTL.
// Every macro expects clk_i and rst_ni in scope at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/e2c_pkg.sv
// Shared types, constants and the month table of the epoch to calendar converter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package e2c_pkg;

  localparam int SplitStages = 4;
  localparam int DateStages  = 7;
  localparam int NumStages   = SplitStages + DateStages;

  localparam logic RegZoneOffset = 1'b0;

  localparam logic [35:0] BaseSeconds = 36'd978307200;
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [27:0] DayRecip    = 28'd203613264;
  localparam logic [16:0] ZoneReset   = 17'd28800;

  localparam logic [17:0] Days400Y = 18'd146097;
  localparam logic [17:0] Days100Y = 18'd36524;
  localparam logic [15:0] Days4Y   = 16'd1461;
  localparam logic [10:0] Days1Y   = 11'd365;
  localparam logic [15:0] Recip4Y  = 16'd45934;
  localparam logic [4:0]  Last4Y   = 5'd24;
  localparam logic [11:0] FirstYear = 12'd2001;

  localparam logic [12:0] HourRecip = 13'd4661;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [12:0] MinRecip  = 13'd4370;
  localparam logic [11:0] SecsPerMin = 12'd60;

  typedef struct packed {
    logic [17:0] days;
    logic [16:0] tod;
  } day_split_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  function automatic logic [8:0] month_start(logic [3:0] mon, logic leap);
    logic [8:0] start;
    case (mon)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd59;
      4'd3:    start = 9'd90;
      4'd4:    start = 9'd120;
      4'd5:    start = 9'd151;
      4'd6:    start = 9'd181;
      4'd7:    start = 9'd212;
      4'd8:    start = 9'd243;
      4'd9:    start = 9'd273;
      4'd10:   start = 9'd304;
      4'd11:   start = 9'd334;
      default: start = 9'd0;
    endcase
    if (leap && (mon >= 4'd2)) begin
      start = start + 9'd1;
    end
    return start;
  endfunction

endpackage

>>> sv/e2c_daysplit.sv
// Front stages: applies the zone offset and splits local seconds into days and time of day.
// Four register stages; uses e2c_pkg.
`timescale 1ns / 1ps

module e2c_daysplit (
  input  logic                      clk_i,
  input  logic [3:0]                en_i,
  input  logic [33:0]               epoch_seconds_i,
  input  logic [16:0]               zone_offset_i,
  output logic                      ok_o,
  output e2c_pkg::day_split_t       split_o
);

  logic [35:0] diff_d;
  logic [33:0] s0_sec_q;
  logic        s0_ok_q;
  logic [54:0] prod_d;
  logic [33:0] s1_sec_q;
  logic [17:0] s1_qe_q;
  logic [33:0] qmul_d;
  logic [33:0] rem_d;
  logic [17:0] s2_qe_q;
  logic [17:0] s2_rem_q;
  logic [17:0] s3_days_q;
  logic [16:0] s3_tod_q;

  assign diff_d = {2'b00, epoch_seconds_i} + {{19{zone_offset_i[16]}}, zone_offset_i}
                  - e2c_pkg::BaseSeconds;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s0_sec_q <= diff_d[33:0];
      s0_ok_q  <= ~diff_d[35];
    end
  end

  assign prod_d = {28'd0, s0_sec_q[33:7]} * {27'd0, e2c_pkg::DayRecip};

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s1_sec_q <= s0_sec_q;
      s1_qe_q  <= prod_d[54:37];
    end
  end

  assign qmul_d = {16'd0, s1_qe_q} * {17'd0, e2c_pkg::SecsPerDay};
  assign rem_d  = s1_sec_q - qmul_d;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s2_qe_q  <= s1_qe_q;
      s2_rem_q <= rem_d[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      if (s2_rem_q >= {1'b0, e2c_pkg::SecsPerDay}) begin
        s3_days_q <= s2_qe_q + 18'd1;
        s3_tod_q  <= 17'(s2_rem_q - {1'b0, e2c_pkg::SecsPerDay});
      end else begin
        s3_days_q <= s2_qe_q;
        s3_tod_q  <= s2_rem_q[16:0];
      end
    end
  end

  assign ok_o         = s0_ok_q;
  assign split_o.days = s3_days_q;
  assign split_o.tod  = s3_tod_q;

endmodule

>>> sv/e2c_date.sv
// Date stages: splits the day count into Gregorian cycles, then month and day of month.
// Seven register stages, the last one the output register; uses e2c_pkg.
`timescale 1ns / 1ps

module e2c_date (
  input  logic        clk_i,
  input  logic [6:0]  en_i,
  input  logic [17:0] days_i,
  input  logic        ok_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic        date_valid_o
);

  logic        s4_c400_q;
  logic [17:0] s4_r1_q;
  logic [1:0]  c100_d;
  logic [17:0] r2_d;
  logic        s5_c400_q;
  logic [1:0]  s5_c100_q;
  logic [15:0] s5_r2_q;
  logic [31:0] p4_d;
  logic        s6_c400_q;
  logic [1:0]  s6_c100_q;
  logic [4:0]  s6_c4_q;
  logic [15:0] s6_r2_q;
  logic [15:0] r3_d;
  logic        s7_c400_q;
  logic [1:0]  s7_c100_q;
  logic [4:0]  s7_c4_q;
  logic [10:0] s7_r3_q;
  logic [1:0]  c1_d;
  logic [11:0] year_d;
  logic        leap_d;
  logic [10:0] r4_d;
  logic [11:0] s8_year_q;
  logic        s8_leap_q;
  logic [8:0]  s8_r4_q;
  logic [3:0]  mon_d;
  logic [11:0] s9_year_q;
  logic        s9_leap_q;
  logic [8:0]  s9_r4_q;
  logic [3:0]  s9_mon_q;
  logic [8:0]  day_d;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      if (days_i >= e2c_pkg::Days400Y) begin
        s4_c400_q <= 1'b1;
        s4_r1_q   <= days_i - e2c_pkg::Days400Y;
      end else begin
        s4_c400_q <= 1'b0;
        s4_r1_q   <= days_i;
      end
    end
  end

  always_comb begin
    c100_d = 2'd0;
    if (s4_r1_q >= e2c_pkg::Days100Y) begin
      c100_d = 2'd1;
    end
    if (s4_r1_q >= 18'(2 * e2c_pkg::Days100Y)) begin
      c100_d = 2'd2;
    end
    if (s4_r1_q >= 18'(3 * e2c_pkg::Days100Y)) begin
      c100_d = 2'd3;
    end
    r2_d = s4_r1_q - 18'(c100_d) * e2c_pkg::Days100Y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s5_c400_q <= s4_c400_q;
      s5_c100_q <= c100_d;
      s5_r2_q   <= r2_d[15:0];
    end
  end

  assign p4_d = {16'd0, s5_r2_q} * {16'd0, e2c_pkg::Recip4Y};

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s6_c400_q <= s5_c400_q;
      s6_c100_q <= s5_c100_q;
      s6_c4_q   <= p4_d[30:26];
      s6_r2_q   <= s5_r2_q;
    end
  end

  assign r3_d = s6_r2_q - 16'(s6_c4_q) * e2c_pkg::Days4Y;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s7_c400_q <= s6_c400_q;
      s7_c100_q <= s6_c100_q;
      s7_c4_q   <= s6_c4_q;
      s7_r3_q   <= r3_d[10:0];
    end
  end

  always_comb begin
    c1_d = 2'd0;
    if (s7_r3_q >= e2c_pkg::Days1Y) begin
      c1_d = 2'd1;
    end
    if (s7_r3_q >= 11'(2 * e2c_pkg::Days1Y)) begin
      c1_d = 2'd2;
    end
    if (s7_r3_q >= 11'(3 * e2c_pkg::Days1Y)) begin
      c1_d = 2'd3;
    end
    r4_d   = s7_r3_q - 11'(c1_d) * e2c_pkg::Days1Y;
    leap_d = (c1_d == 2'd3) && ((s7_c4_q != e2c_pkg::Last4Y) || (s7_c100_q == 2'd3));
    year_d = e2c_pkg::FirstYear + (s7_c400_q ? 12'd400 : 12'd0)
             + 12'(s7_c100_q) * 12'd100 + {5'd0, s7_c4_q, 2'b00} + {10'd0, c1_d};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s8_year_q <= year_d;
      s8_leap_q <= leap_d;
      s8_r4_q   <= r4_d[8:0];
    end
  end

  always_comb begin
    mon_d = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s8_r4_q >= e2c_pkg::month_start(4'(m), s8_leap_q)) begin
        mon_d = 4'(m);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s9_year_q <= s8_year_q;
      s9_leap_q <= s8_leap_q;
      s9_r4_q   <= s8_r4_q;
      s9_mon_q  <= mon_d;
    end
  end

  assign day_d = s9_r4_q - e2c_pkg::month_start(s9_mon_q, s9_leap_q) + 9'd1;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      date_valid_o <= ok_i;
      if (ok_i) begin
        year_o  <= s9_year_q;
        month_o <= s9_mon_q + 4'd1;
        day_o   <= day_d[4:0];
      end else begin
        year_o  <= 12'd0;
        month_o <= 4'd0;
        day_o   <= 5'd0;
      end
    end
  end

endmodule

>>> sv/e2c_clock.sv
// Time-of-day stages: splits seconds of the day into hour, minute and second.
// Seven register stages aligned with the date stages; uses e2c_pkg.
`timescale 1ns / 1ps

module e2c_clock (
  input  logic        clk_i,
  input  logic [6:0]  en_i,
  input  logic [16:0] tod_i,
  input  logic        ok_i,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  logic [25:0]         ph_d;
  logic [4:0]          s4_hour_q;
  logic [16:0]         s4_tod_q;
  logic [16:0]         trem_d;
  logic [4:0]          s5_hour_q;
  logic [11:0]         s5_trem_q;
  logic [22:0]         pm_d;
  logic [4:0]          s6_hour_q;
  logic [5:0]          s6_min_q;
  logic [11:0]         s6_trem_q;
  logic [11:0]         sec_d;
  e2c_pkg::hms_t       s7_hms_q;
  e2c_pkg::hms_t       s8_hms_q;
  e2c_pkg::hms_t       s9_hms_q;

  assign ph_d = {13'd0, tod_i[16:4]} * {13'd0, e2c_pkg::HourRecip};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s4_hour_q <= ph_d[24:20];
      s4_tod_q  <= tod_i;
    end
  end

  assign trem_d = s4_tod_q - 17'(s4_hour_q) * e2c_pkg::SecsPerHour;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s5_hour_q <= s4_hour_q;
      s5_trem_q <= trem_d[11:0];
    end
  end

  assign pm_d = {13'd0, s5_trem_q[11:2]} * {10'd0, e2c_pkg::MinRecip};

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s6_hour_q <= s5_hour_q;
      s6_min_q  <= pm_d[21:16];
      s6_trem_q <= s5_trem_q;
    end
  end

  assign sec_d = s6_trem_q - 12'(s6_min_q) * e2c_pkg::SecsPerMin;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s7_hms_q.hour   <= s6_hour_q;
      s7_hms_q.minute <= s6_min_q;
      s7_hms_q.second <= sec_d[5:0];
    end
    if (en_i[4]) begin
      s8_hms_q <= s7_hms_q;
    end
    if (en_i[5]) begin
      s9_hms_q <= s8_hms_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      if (ok_i) begin
        hour_o   <= s9_hms_q.hour;
        minute_o <= s9_hms_q.minute;
        second_o <= s9_hms_q.second;
      end else begin
        hour_o   <= 5'd0;
        minute_o <= 6'd0;
        second_o <= 6'd0;
      end
    end
  end

endmodule

>>> sv/epoch_seconds_to_calendar.sv
// Epoch seconds to local Gregorian calendar date and time of day.
// The input channel takes a word of epoch seconds and microseconds under valid and ready;
// the output channel returns year, month, day, hour, minute, second, microseconds and a
// flag that is low for local times before 2001-01-01, again under valid and ready.
// The zone offset register sits at byte address 0 of the APB port and holds signed
// seconds added to UTC; the user must write it only while no word is in flight, since the
// block has no check for this. The pipeline has eleven register stages and accepts one
// word per cycle when the output is taken.
// Each stage has its own valid bit and loads whenever it is empty or the stage after it
// moves, so empty stages close up while the receiver stalls.
// Input ready falls only when all eleven stages hold words and the receiver stalls.
// Reset clears every valid bit and loads the offset with +8 hours.
// Microseconds ride the pipeline unchanged. Uses e2c_pkg and the three stage modules.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [33:0] epoch_seconds_i,
  input  logic [19:0] micro_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o,
  output logic [19:0] micro_out_o,
  output logic        date_valid_o
);

  localparam int NS = e2c_pkg::NumStages;
  localparam int SS = e2c_pkg::SplitStages;

  logic [16:0]         zone_q;
  logic [NS:0]         en;
  logic [NS-1:0]       valid_q;
  logic [19:0]         micro_q [NS];
  logic [NS-2:1]       ok_q;
  logic                ok0;
  e2c_pkg::day_split_t split;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == e2c_pkg::RegZoneOffset) ? {{15{zone_q[16]}}, zone_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= e2c_pkg::ZoneReset;
    end else if (psel && penable && pwrite && (paddr[2] == e2c_pkg::RegZoneOffset)) begin
      zone_q <= pwdata[16:0];
    end
  end

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      micro_q[0] <= micro_seconds_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        micro_q[k] <= micro_q[k-1];
      end
    end
    if (en[1]) begin
      ok_q[1] <= ok0;
    end
    for (int k = 2; k < NS - 1; k++) begin
      if (en[k]) begin
        ok_q[k] <= ok_q[k-1];
      end
    end
  end

  assign micro_out_o = micro_q[NS-1];

  e2c_daysplit u_daysplit (
    .clk_i           (clk_i),
    .en_i            (en[SS-1:0]),
    .epoch_seconds_i (epoch_seconds_i),
    .zone_offset_i   (zone_q),
    .ok_o            (ok0),
    .split_o         (split)
  );

  e2c_date u_date (
    .clk_i        (clk_i),
    .en_i         (en[NS-1:SS]),
    .days_i       (split.days),
    .ok_i         (ok_q[NS-2]),
    .year_o       (year_out_o),
    .month_o      (month_out_o),
    .day_o        (day_out_o),
    .date_valid_o (date_valid_o)
  );

  e2c_clock u_clock (
    .clk_i    (clk_i),
    .en_i     (en[NS-1:SS]),
    .tod_i    (split.tod),
    .ok_i     (ok_q[NS-2]),
    .hour_o   (hour_out_o),
    .minute_o (minute_out_o),
    .second_o (second_out_o)
  );

  `ASSERT_IMPL(a_stall_only_full, !in_ready_o, out_valid_o && !out_ready_i,
               "input stalled without a full pipe")
  `ASSERT_IMPL(a_invalid_zeroed, out_valid_o && !date_valid_o,
               (year_out_o == 12'd0) && (month_out_o == 4'd0) && (day_out_o == 5'd0)
               && (hour_out_o == 5'd0),
               "date before 2001 not cleared")
  `ASSERT_IMPL(a_date_range, out_valid_o && date_valid_o,
               (year_out_o >= e2c_pkg::FirstYear) && (month_out_o >= 4'd1)
               && (month_out_o <= 4'd12) && (day_out_o >= 5'd1),
               "date out of range")
  `ASSERT_IMPL(a_time_range, out_valid_o && date_valid_o,
               (hour_out_o <= 5'd23) && (minute_out_o <= 6'd59) && (second_out_o <= 6'd59),
               "time of day out of range")

endmodule

>>> test/e2c_calendar_checker.sv
// Checker for the epoch to calendar converter: watches the APB port and both word channels.
// Predicts each calendar word from the accepted input word and compares it field by field.
// Depends on e2c_pkg for the register index and the reset value of the zone offset.
`timescale 1ns / 1ps

module e2c_calendar_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [33:0] epoch_seconds_i,
  input  logic [19:0] micro_seconds_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  input  logic [19:0] micro_i,
  input  logic        date_valid_i,
  output int          mismatches_o,
  output int          pending_o
);

  localparam logic [2:0] ZoneAddr = {e2c_pkg::RegZoneOffset, 2'b00};

  localparam longint DaySeconds = 86400;
  localparam longint DaysTo2001 = 365 * 31 + 8;
  localparam longint Cycle400   = 146097;
  localparam longint Cycle100   = 36524;
  localparam longint Cycle4     = 1461;
  localparam longint YearDays   = 365;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] micro;
    logic        date_ok;
  } calendar_t;

  calendar_t         dates_due[$];
  calendar_t         seen;
  calendar_t         want;
  logic signed [16:0] zone = e2c_pkg::ZoneReset;

  function automatic bit leap_year(longint yr);
    return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
  endfunction

  function automatic longint month_days(int mon, longint yr);
    case (mon)
      1:          return leap_year(yr) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic calendar_t convert_time(logic [33:0] secs, logic [19:0] usec,
                                             logic signed [16:0] offset);
    calendar_t res;
    longint    loc;
    longint    rem;
    longint    tod;
    longint    c400;
    longint    c100;
    longint    c4;
    longint    c1;
    longint    yr;
    int        mon;
    res = '0;
    res.micro = usec;
    loc = longint'(secs) + longint'(offset);
    if (loc < DaysTo2001 * DaySeconds) begin
      return res;
    end
    rem  = loc / DaySeconds - DaysTo2001;
    tod  = loc % DaySeconds;
    c400 = rem / Cycle400;
    rem  = rem - c400 * Cycle400;
    c100 = rem / Cycle100;
    if (c100 > 3) begin
      c100 = 3;
    end
    rem = rem - c100 * Cycle100;
    c4  = rem / Cycle4;
    rem = rem - c4 * Cycle4;
    c1  = rem / YearDays;
    if (c1 > 3) begin
      c1 = 3;
    end
    rem = rem - c1 * YearDays;
    yr  = 2001 + 400 * c400 + 100 * c100 + 4 * c4 + c1;
    mon = 0;
    while (mon < 11 && rem >= month_days(mon, yr)) begin
      rem = rem - month_days(mon, yr);
      mon++;
    end
    res.year    = yr[11:0];
    res.month   = 4'(mon + 1);
    res.day     = 5'(rem + 1);
    res.hour    = 5'(tod / 3600);
    res.minute  = 6'((tod / 60) % 60);
    res.second  = 6'(tod % 60);
    res.date_ok = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t e2c_calendar_checker: %s", $realtime, msg);
    mismatches_o++;
  endtask

  task automatic check_field(input string name, input longint got, input longint exp_val);
    if (got != exp_val) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      zone = e2c_pkg::ZoneReset;
      dates_due.delete();
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ZoneAddr) begin
        zone = pwdata[16:0];
      end
      if (in_valid_i && in_ready_i) begin
        dates_due.push_back(convert_time(epoch_seconds_i, micro_seconds_i, zone));
      end
      if (out_valid_i && out_ready_i) begin
        seen = '{year_i, month_i, day_i, hour_i, minute_i, second_i, micro_i, date_valid_i};
        if (dates_due.size() == 0) begin
          report_mismatch("calendar word arrived with nothing expected");
        end else begin
          want = dates_due.pop_front();
          check_field("year", seen.year, want.year);
          check_field("month", seen.month, want.month);
          check_field("day", seen.day, want.day);
          check_field("hour", seen.hour, want.hour);
          check_field("minute", seen.minute, want.minute);
          check_field("second", seen.second, want.second);
          check_field("micro", seen.micro, want.micro);
          check_field("date_valid", seen.date_ok, want.date_ok);
        end
      end
      pending_o = dates_due.size();
    end
  end

endmodule

>>> test/tb_epoch_seconds_to_calendar.sv
// Testbench top for the epoch to calendar converter: clock, reset, APB writes and word stimulus.
// Checking is done by e2c_calendar_checker beside the block; depends on e2c_pkg and the RTL.
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar;

  localparam logic [2:0] ZoneAddr = {e2c_pkg::RegZoneOffset, 2'b00};
  localparam int PhaseCount    = 7;
  localparam int WordsPerPhase = 236;
  localparam int HoldPhase     = 2;
  localparam int CalmPhase     = 4;
  localparam int HoldCycles    = 300;
  localparam int TailCycles    = 40;
  localparam int CycleLimit    = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [33:0] epoch_seconds_i;
  logic [19:0] micro_seconds_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [11:0] year_out_o;
  logic [3:0]  month_out_o;
  logic [4:0]  day_out_o;
  logic [4:0]  hour_out_o;
  logic [5:0]  minute_out_o;
  logic [5:0]  second_out_o;
  logic [19:0] micro_out_o;
  logic        date_valid_o;

  int mismatches;
  int pending;
  int phase_idx;
  bit calm_phase;
  int zone_now;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  epoch_seconds_to_calendar uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .epoch_seconds_i (epoch_seconds_i),
    .micro_seconds_i (micro_seconds_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .year_out_o      (year_out_o),
    .month_out_o     (month_out_o),
    .day_out_o       (day_out_o),
    .hour_out_o      (hour_out_o),
    .minute_out_o    (minute_out_o),
    .second_out_o    (second_out_o),
    .micro_out_o     (micro_out_o),
    .date_valid_o    (date_valid_o)
  );

  e2c_calendar_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .epoch_seconds_i (epoch_seconds_i),
    .micro_seconds_i (micro_seconds_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .year_i          (year_out_o),
    .month_i         (month_out_o),
    .day_i           (day_out_o),
    .hour_i          (hour_out_o),
    .minute_i        (minute_out_o),
    .second_i        (second_out_o),
    .micro_i         (micro_out_o),
    .date_valid_i    (date_valid_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      return $urandom_range(0, 3);
    end else if (roll < 9) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [33:0] clamp_epoch(longint secs);
    if (secs < 0) begin
      return '0;
    end else if (secs > longint'(34'h3_FFFF_FFFF)) begin
      return '1;
    end
    return secs[33:0];
  endfunction

  // Epoch seconds that land on a given local day of a year and second of that day.
  function automatic logic [33:0] epoch_for(int yr, int doy, int tod);
    longint n;
    longint d;
    n = yr - 1;
    d = longint'(yr - 2001) * 365 + (n / 4 - n / 100 + n / 400)
        - (2000 / 4 - 2000 / 100 + 2000 / 400) + doy;
    return clamp_epoch(longint'(e2c_pkg::BaseSeconds) + d * 86400 + tod - zone_now);
  endfunction

  task automatic offer(input logic [33:0] secs, input logic [19:0] usec);
    int gap;
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= secs;
    micro_seconds_i <= usec;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    gap = calm_phase ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic offer_random();
    logic [33:0] secs;
    logic [19:0] usec;
    int          tod;
    int          doy;
    tod = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) * 86399)
                                      : $urandom_range(0, 86399);
    case ($urandom_range(0, 9))
      0, 1, 2: secs = {2'($urandom_range(0, 3)), 32'($urandom)};
      3: secs = clamp_epoch(longint'(e2c_pkg::BaseSeconds) - zone_now
                            + longint'($urandom_range(0, 400000)) - 200000);
      4: secs = 34'($urandom_range(0, 100000));
      5: begin
        case ($urandom_range(0, 4))
          0:       doy = 0;
          1:       doy = 58;
          2:       doy = 59;
          3:       doy = $urandom_range(364, 365);
          default: doy = $urandom_range(0, 364);
        endcase
        secs = epoch_for($urandom_range(2001, 2513), doy, tod);
      end
      default: secs = epoch_for(2001, $urandom_range(0, 185000), tod);
    endcase
    usec = ($urandom_range(0, 4) == 0) ? 20'($urandom) : 20'($urandom_range(0, 999999));
    offer(secs, usec);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic program_zone(input int value, input logic [14:0] upper);
    psel     <= 1'b1;
    penable  <= 1'b0;
    pwrite   <= 1'b1;
    paddr    <= ZoneAddr;
    pwdata   <= {upper, value[16:0]};
    zone_now = value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : receiver
    bit held;
    int gap;
    held        = 1'b0;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) begin
      @(posedge clk_i);
    end
    forever begin
      if (phase_idx == HoldPhase && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (calm_phase) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_epoch_seconds_to_calendar: FAIL");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int n;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    epoch_seconds_i = '0;
    micro_seconds_i = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    phase_idx       = 0;
    calm_phase      = 1'b0;
    zone_now        = int'($signed(e2c_pkg::ZoneReset));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset offset: field extremes, the 2001 boundary, leap days
    // and the last days of 4-, 100- and 400-year cycles.
    offer(34'd0, 20'd0);
    offer('1, 20'hF_FFFF);
    offer(epoch_for(2001, 0, 0), 20'd999999);
    offer(epoch_for(2001, 0, 0) - 34'd1, 20'd1);
    offer(epoch_for(2001, 0, 86399), 20'd524288);
    offer(epoch_for(2001, 364, 86399), 20'd0);
    offer(epoch_for(2004, 59, 43210), 20'd999999);
    offer(epoch_for(2004, 365, 86399), 20'h5_5555);
    offer(epoch_for(2005, 0, 0), 20'hA_AAAA);
    offer(epoch_for(2096, 365, 12345), 20'd0);
    offer(epoch_for(2100, 58, 3661), 20'd17);
    offer(epoch_for(2100, 59, 0), 20'd999999);
    offer(epoch_for(2100, 364, 86399), 20'd3);
    offer(epoch_for(2101, 0, 0), 20'hF_FFFF);
    offer(epoch_for(2300, 364, 0), 20'd42);
    offer(epoch_for(2400, 59, 0), 20'd0);
    offer(epoch_for(2400, 365, 86399), 20'd999999);
    offer(epoch_for(2401, 0, 0), 20'd1);
    offer(epoch_for(2500, 59, 45296), 20'd123456);
    offer(epoch_for(2514, 0, 0), 20'd0);
    for (n = 0; n < WordsPerPhase; n++) begin
      offer_random();
    end
    drain_results();

    for (phase = 1; phase < PhaseCount; phase++) begin
      case (phase)
        1:       program_zone(-50400, 15'd0);
        2:       program_zone(50400, 15'd0);
        3:       program_zone(-65536, 15'($urandom));
        4:       program_zone(0, 15'd0);
        5:       program_zone(65535, 15'($urandom));
        default: program_zone(int'($urandom_range(0, 100800)) - 50400, 15'd0);
      endcase
      calm_phase = (phase == CalmPhase);
      phase_idx  = phase;
      for (n = 0; n < WordsPerPhase; n++) begin
        offer_random();
      end
      drain_results();
    end

    calm_phase = 1'b0;
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_epoch_seconds_to_calendar: PASS");
    end else begin
      $display("tb_epoch_seconds_to_calendar: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/e2c_pkg.sv
sv/e2c_daysplit.sv
sv/e2c_date.sv
sv/e2c_clock.sv
sv/epoch_seconds_to_calendar.sv
test/e2c_calendar_checker.sv
test/tb_epoch_seconds_to_calendar.sv
